// ----- sv/sipa_pkg.sv -----
// Shared types and constants of the scan-index pixel averager.
package sipa_pkg;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int SAMPLE_W = 16;
  localparam int CLASS_W  = 6;
  localparam int POS_W    = 12;
  localparam int PAL_W    = 24;

  // Accumulator and register widths
  localparam int SUM_W    = 18;
  localparam int TOT_W    = SUM_W + 1;
  localparam int CNT_W    = 2;
  localparam int AVG_W    = 2;
  localparam int SSH_W    = 4;
  localparam int CSH_W    = 5;
  localparam int MASK_W   = 64;
  localparam int WIDTH_W  = 13;

  // Configuration port
  localparam int CFG_DW   = 64;
  localparam int CFG_AW   = 5;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(4096);

  // Register reset values
  localparam logic [SSH_W-1:0]   SSH_RST   = '0;
  localparam logic [CSH_W-1:0]   CSH_RST   = CSH_W'(8);
  localparam logic [MASK_W-1:0]  MASK_RST  = {MASK_W{1'b1}};
  localparam logic [WIDTH_W-1:0] WIDTH_RST = WIDTH_W'(640);

  typedef enum logic [KIND_W-1:0] {
    KIND_ACC    = 2'd0,
    KIND_LAST   = 2'd1,
    KIND_NODATA = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_MEAN_RSH  = 2'd0,
    REG_CLS_LSH   = 2'd1,
    REG_SHOW_MASK = 2'd2,
    REG_ROW_WIDTH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SSH_W-1:0]   mean_rsh;
    logic [CSH_W-1:0]   cls_lsh;
    logic [MASK_W-1:0]  show_class_mask;
    logic [WIDTH_W-1:0] row_width;
  } cfg_t;

  // One finished pixel handed from front to back
  typedef struct packed {
    logic               show;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic [TOT_W-1:0]   total;
    logic [AVG_W-1:0]   avg_sh;
    logic [CLASS_W-1:0] cls;
  } pixel_cmd_t;

endpackage

// ----- sv/sipa_if.sv -----
// Valid/ready channel interfaces for entries and pixel results.
interface sipa_in_if
  import sipa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   entry_kind;
  logic [SAMPLE_W-1:0] sample_value;
  logic [CLASS_W-1:0]  sample_class;

  modport source (output valid, entry_kind, sample_value, sample_class, input ready);
  modport sink   (input valid, entry_kind, sample_value, sample_class, output ready);
endinterface

interface sipa_out_if
  import sipa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             write_pixel;
  logic [POS_W-1:0] pixel_col;
  logic [POS_W-1:0] pixel_row;
  logic [PAL_W-1:0] palette_index;

  modport source (output valid, write_pixel, pixel_col, pixel_row, palette_index,
                  input ready);
  modport sink   (input valid, write_pixel, pixel_col, pixel_row, palette_index,
                  output ready);
endinterface

// ----- sv/sipa_cfg.sv -----
// APB-style configuration register file.
module sipa_cfg
  import sipa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // Decode the write request
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MEAN_RSH:  cfg_nxt.mean_rsh        = pwdata[SSH_W-1:0];
        REG_CLS_LSH:   cfg_nxt.cls_lsh         = pwdata[CSH_W-1:0];
        REG_SHOW_MASK: cfg_nxt.show_class_mask = pwdata[MASK_W-1:0];
        REG_ROW_WIDTH: cfg_nxt.row_width       = pwdata[WIDTH_W-1:0];
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (idx)
      REG_MEAN_RSH:  prdata = CFG_DW'(cfg_r.mean_rsh);
      REG_CLS_LSH:   prdata = CFG_DW'(cfg_r.cls_lsh);
      REG_SHOW_MASK: prdata = CFG_DW'(cfg_r.show_class_mask);
      REG_ROW_WIDTH: prdata = CFG_DW'(cfg_r.row_width);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mean_rsh        <= SSH_RST;
      cfg_r.cls_lsh         <= CSH_RST;
      cfg_r.show_class_mask <= MASK_RST;
      cfg_r.row_width       <= WIDTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- sv/sipa_front.sv -----
// Front end: accepts entries, accumulates samples and tracks the pixel position.
module sipa_front
  import sipa_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int NUM_CLASSES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  sipa_in_if.sink    in_ch,
  input  logic       q_full,
  output logic       q_push,
  output pixel_cmd_t q_data
);

  localparam logic [SAMPLE_W-1:0] SAMP_MASK =
    SAMPLE_W'((64'(1) << SAMPLE_BITS) - 64'(1));
  localparam logic [CLASS_W:0] NCLS = (CLASS_W + 1)'(NUM_CLASSES);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;

  logic                accept;
  kind_t               kind;
  logic [SAMPLE_W-1:0] samp;
  logic [TOT_W-1:0]    total;
  logic [WIDTH_W-1:0]  eff_width;
  logic [POS_W-1:0]    col_inc;
  logic                visible;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign kind        = kind_t'(in_ch.entry_kind);
  assign samp        = in_ch.sample_value & SAMP_MASK;
  assign total       = {1'b0, sum_r} + TOT_W'(samp);

  // Clamp row width into one to 4096
  always_comb begin
    priority if (cfg.row_width == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (cfg.row_width > WIDTH_MAX) begin
      eff_width = WIDTH_MAX;
    end else begin
      eff_width = cfg.row_width;
    end
  end

  assign visible = ({1'b0, in_ch.sample_class} < NCLS) &&
                   cfg.show_class_mask[in_ch.sample_class];

  // Classify the entry and update accumulator state
  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      unique case (kind)
        KIND_ACC: begin
          sum_nxt = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
          if (cnt_r != CNT_MAX) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        KIND_LAST: begin
          sum_nxt = '0;
          cnt_nxt = '0;
        end
        KIND_NODATA, KIND_RSVD: begin
        end
      endcase
    end
  end

  // Advance the pixel position once per finished pixel
  assign col_inc = col_r + POS_W'(1);
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (q_push) begin
      if ({1'b0, col_inc} >= eff_width) begin
        col_nxt = '0;
        row_nxt = row_r + POS_W'(1);
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  // Hand the finished pixel to the back end
  assign q_push = accept && (kind != KIND_ACC);
  always_comb begin
    q_data.show   = (kind == KIND_LAST) && visible;
    q_data.col    = col_r;
    q_data.row    = row_r;
    q_data.total  = total;
    q_data.avg_sh = AVG_W'(({1'b0, cnt_r} + 3'd1) >> 1);
    q_data.cls    = in_ch.sample_class;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- sv/sipa_queue.sv -----
// Short queue of finished pixels between front and back end.
module sipa_queue
  import sipa_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pixel_cmd_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output pixel_cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pixel_cmd_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pixel at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/sipa_back.sv -----
// Back end: averages, scales and offsets the sample into a palette index.
module sipa_back
  import sipa_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_not_empty,
  input  pixel_cmd_t q_head,
  output logic       q_pop,
  sipa_out_if.source out_ch
);

  localparam logic [SSH_W:0] SB = (SSH_W + 1)'(SAMPLE_BITS);

  logic             out_valid_r, out_valid_nxt;
  logic             write_r;
  logic [POS_W-1:0] col_r;
  logic [POS_W-1:0] row_r;
  logic [PAL_W-1:0] pal_r;

  logic [TOT_W-1:0] mean;
  logic [TOT_W-1:0] scaled;
  logic [TOT_W-1:0] keep_mask;
  logic [PAL_W-1:0] cls_off;
  logic [PAL_W-1:0] pal;

  // Take the head when the output register is free or drains
  assign q_pop = q_not_empty && (!out_valid_r || out_ch.ready);

  // Average, scale, mask and offset by class
  always_comb begin
    mean   = q_head.total >> q_head.avg_sh;
    scaled = mean >> cfg.mean_rsh;
    if ({1'b0, cfg.mean_rsh} < SB) begin
      keep_mask = (TOT_W'(1) << (SB - {1'b0, cfg.mean_rsh})) - TOT_W'(1);
    end else begin
      keep_mask = '0;
    end
    cls_off = PAL_W'(q_head.cls) << cfg.cls_lsh;
    pal     = PAL_W'(scaled & keep_mask) + cls_off;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      write_r <= q_head.show;
      col_r   <= q_head.col;
      row_r   <= q_head.row;
      pal_r   <= q_head.show ? pal : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_pixel   = write_r;
  assign out_ch.pixel_col     = col_r;
  assign out_ch.pixel_row     = row_r;
  assign out_ch.palette_index = pal_r;

endmodule

// ----- sv/scan_index_pixel_averager_top.sv -----
// Top level of the scan-index pixel averager.
//
// in_ch carries scan-converter entries (kind, sample, class). Accumulate
// entries only update the running sum and count and produce no request on
// out_ch; last, no-data and reserved entries each produce one pixel request with its
// column, row, draw flag and palette index.
// Throughput: one entry per cycle, sustained while out_ch takes results.
// An accepted pixel entry is written into the queue, and the back end then
// loads it from the queue head into its output register, which drives out_ch.
// The front end holds the accumulator and position counters; a two-entry
// queue decouples it from the back end, which does the averaging shift, the
// scale and mask and the class offset in one stage into its output register.
// When out_ch stalls, the output register holds, the queue fills, and
// in_ch.ready drops once the queue is full; no request is lost.
// Reset (rst_n low, synchronous) clears sum, count, position, the queue and
// the output valid, and loads the register reset values.
// Configuration registers sit on the APB port at byte addresses 0, 8, 16, 24;
// write them only while no entry is in flight.
module scan_index_pixel_averager_top
  import sipa_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int NUM_CLASSES = 64,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  sipa_in_if.sink           in_ch,
  sipa_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_not_empty;
  pixel_cmd_t q_in;
  pixel_cmd_t q_head;

  sipa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sipa_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  sipa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  sipa_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule
